// ===== hw/rtl/svcs_pkg.sv =====
// svcs_pkg: shared types, constants and pattern match functions for the
// view clause scanner. no dependencies.
`timescale 1ns / 1ps

package svcs_pkg;

  localparam int unsigned MatchWindow = 10;
  localparam int unsigned CellCount   = MatchWindow - 1;

  typedef logic [7:0] char_t;
  typedef char_t [MatchWindow-1:0] win_t;

  localparam char_t ChSpace = 8'h20;
  localparam char_t ChQuote = 8'h27;
  localparam char_t ChDash  = 8'h2d;
  localparam char_t ChSlash = 8'h2f;
  localparam char_t ChStar  = 8'h2a;
  localparam char_t ChLf    = 8'h0a;
  localparam char_t ChTab   = 8'h09;
  localparam char_t ChVt    = 8'h0b;
  localparam char_t ChFf    = 8'h0c;
  localparam char_t ChCr    = 8'h0d;
  localparam char_t ChLowA  = 8'h61;
  localparam char_t ChLowZ  = 8'h7a;
  localparam char_t CaseBit = 8'h20;

  typedef enum logic [1:0] {
    ModeCode  = 2'd0,
    ModeStr   = 2'd1,
    ModeLine  = 2'd2,
    ModeBlock = 2'd3
  } lex_mode_t;

  // flag bit positions
  localparam int unsigned FlagJoin  = 0;
  localparam int unsigned FlagGroup = 1;
  localparam int unsigned FlagWhere = 2;
  localparam int unsigned FlagAgg   = 3;

  typedef logic [3:0] flags_t;

  // one normalized character handed from the lexer to the window
  typedef struct packed {
    logic  push;
    char_t ch;
    logic  last;
    logic  seen;
  } tok_t;

  typedef struct packed {
    logic shift;
    logic clr;
  } cell_ctl_t;

  localparam int unsigned PatBits = 8 * MatchWindow;
  typedef logic [PatBits-1:0] pat_t;

  // literals are right aligned: last character in the lowest byte
  localparam pat_t PatJoin   = " JOIN ";
  localparam pat_t PatGroup  = " GROUP BY ";
  localparam pat_t PatWhere  = " WHERE ";
  localparam pat_t PatCount  = "COUNT(";
  localparam pat_t PatSum    = "SUM(";
  localparam pat_t PatAvg    = "AVG(";
  localparam pat_t PatMin    = "MIN(";
  localparam pat_t PatMax    = "MAX(";
  localparam pat_t PatList   = "LIST(";
  localparam pat_t PatCountS = "COUNT (";
  localparam pat_t PatSumS   = "SUM (";
  localparam pat_t PatAvgS   = "AVG (";
  localparam pat_t PatMinS   = "MIN (";
  localparam pat_t PatMaxS   = "MAX (";
  localparam pat_t PatListS  = "LIST (";

  // newest character sits at the top index of the window
  function automatic logic tail_eq(win_t w, pat_t pat, int unsigned len);
    logic hit;
    hit = 1'b1;
    for (int unsigned k = 0; k < MatchWindow; k++) begin
      if (k < len && w[MatchWindow-1-k] != pat[8*k +: 8]) begin
        hit = 1'b0;
      end
    end
    return hit;
  endfunction

  function automatic flags_t match_flags(win_t w);
    flags_t f;
    f = '0;
    f[FlagJoin]  = tail_eq(w, PatJoin, 6);
    f[FlagGroup] = tail_eq(w, PatGroup, 10);
    f[FlagWhere] = tail_eq(w, PatWhere, 7);
    f[FlagAgg]   = tail_eq(w, PatCount, 6) | tail_eq(w, PatSum, 4) |
                   tail_eq(w, PatAvg, 4) | tail_eq(w, PatMin, 4) |
                   tail_eq(w, PatMax, 4) | tail_eq(w, PatList, 5) |
                   tail_eq(w, PatCountS, 7) | tail_eq(w, PatSumS, 5) |
                   tail_eq(w, PatAvgS, 5) | tail_eq(w, PatMinS, 5) |
                   tail_eq(w, PatMaxS, 5) | tail_eq(w, PatListS, 6);
    return f;
  endfunction

endpackage

// ===== hw/rtl/svcs_lexer.sv =====
// svcs_lexer: one-byte lookahead lexer, blanks strings and comments,
// upper-cases code and collapses whitespace. depends on svcs_pkg.
`timescale 1ns / 1ps

module svcs_lexer import svcs_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  acc,
  input  logic  action,
  input  char_t data_byte,
  output tok_t  tok_nxt
);

  lex_mode_t mode_r, mode_nxt;
  char_t     held_r, held_nxt;
  logic      held_v_r, held_v_nxt;
  logic      lws_r, lws_nxt;
  logic      seen_r, seen_nxt;

  char_t     look;
  char_t     e_ch;
  lex_mode_t lex_mode_nxt;
  logic      pair;
  logic      sp;

  function automatic logic is_ws(char_t c);
    return c == ChSpace || c == ChTab || c == ChLf || c == ChCr ||
           c == ChFf || c == ChVt;
  endfunction

  always_comb begin
    look         = action ? '0 : data_byte;
    e_ch         = ChSpace;
    pair         = 1'b0;
    lex_mode_nxt = mode_r;
    unique case (mode_r)
      ModeCode: begin
        priority if (held_r == ChQuote) begin
          lex_mode_nxt = ModeStr;
        end else if (held_r == ChDash && look == ChDash) begin
          lex_mode_nxt = ModeLine;
          pair         = 1'b1;
        end else if (held_r == ChSlash && look == ChStar) begin
          lex_mode_nxt = ModeBlock;
          pair         = 1'b1;
        end else if (held_r >= ChLowA && held_r <= ChLowZ) begin
          e_ch = held_r & ~CaseBit;
        end else begin
          e_ch = held_r;
        end
      end
      ModeStr: begin
        priority if (held_r == ChQuote && look == ChQuote) begin
          pair = 1'b1;
        end else if (held_r == ChQuote) begin
          lex_mode_nxt = ModeCode;
        end else begin
          lex_mode_nxt = ModeStr;
        end
      end
      ModeLine: begin
        if (held_r == ChLf) begin
          lex_mode_nxt = ModeCode;
        end
      end
      ModeBlock: begin
        if (held_r == ChStar && look == ChSlash) begin
          lex_mode_nxt = ModeCode;
          pair         = 1'b1;
        end
      end
      default: begin
        lex_mode_nxt = ModeCode;
      end
    endcase

    sp           = is_ws(e_ch);
    tok_nxt.push = held_v_r && !(sp && lws_r);
    tok_nxt.ch   = sp ? ChSpace : e_ch;
    tok_nxt.last = action;
    tok_nxt.seen = action ? seen_r : 1'b1;

    // end item returns the lexer to its reset state
    if (action) begin
      mode_nxt   = ModeCode;
      held_nxt   = '0;
      held_v_nxt = 1'b0;
      lws_nxt    = 1'b0;
      seen_nxt   = 1'b0;
    end else begin
      seen_nxt = 1'b1;
      lws_nxt  = held_v_r ? sp : lws_r;
      mode_nxt = held_v_r ? lex_mode_nxt : mode_r;
      if (held_v_r && pair) begin
        held_nxt   = '0;
        held_v_nxt = 1'b0;
      end else begin
        held_nxt   = data_byte;
        held_v_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= ModeCode;
      held_r   <= '0;
      held_v_r <= 1'b0;
      lws_r    <= 1'b0;
      seen_r   <= 1'b0;
    end else if (acc) begin
      mode_r   <= mode_nxt;
      held_r   <= held_nxt;
      held_v_r <= held_v_nxt;
      lws_r    <= lws_nxt;
      seen_r   <= seen_nxt;
    end
  end

endmodule

// ===== hw/rtl/svcs_cell.sv =====
// svcs_cell: one character slot of the match window, shifts toward the
// older end on each push. depends on svcs_pkg.
`timescale 1ns / 1ps

module svcs_cell import svcs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cell_ctl_t ctl,
  input  char_t     din,
  output char_t     q
);

  char_t ch_r;

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr) begin
      ch_r <= ChSpace;
    end else if (ctl.shift) begin
      ch_r <= din;
    end
  end

  assign q = ch_r;

endmodule

// ===== hw/rtl/svcs_window.sv =====
// svcs_window: row of window cells, pattern compare and found flags.
// depends on svcs_pkg and svcs_cell.
`timescale 1ns / 1ps

module svcs_window import svcs_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   consume,
  input  tok_t   tok,
  output logic   res_v,
  output logic   res_seen,
  output flags_t res_flags
);

  char_t [CellCount-1:0] cell_q;
  cell_ctl_t             ctl;
  flags_t                flags_r, flags_nxt;
  win_t                  win1, win2;
  flags_t                hits1, hits2;

  assign ctl.shift = consume && tok.push;
  assign ctl.clr   = consume && tok.last;

  // cell 0 is the oldest character, the newest enters at the top
  for (genvar i = 0; i < CellCount; i++) begin : g_cell
    char_t din;
    if (i == CellCount - 1) begin : g_head
      assign din = tok.ch;
    end else begin : g_body
      assign din = cell_q[i+1];
    end
    svcs_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (ctl),
      .din   (din),
      .q     (cell_q[i])
    );
  end

  always_comb begin
    win1 = {tok.ch, cell_q};
    // trailing pad space after the last character of the text
    win2 = tok.push ? {ChSpace, win1[MatchWindow-1:1]} : {ChSpace, cell_q};
    hits1     = tok.push ? match_flags(win1) : '0;
    hits2     = tok.last ? match_flags(win2) : '0;
    flags_nxt = flags_r | hits1 | hits2;
    res_v     = consume && tok.last;
    res_seen  = tok.seen;
    res_flags = tok.seen ? flags_nxt : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else if (consume) begin
      flags_r <= tok.last ? '0 : flags_nxt;
    end
  end

endmodule

// ===== hw/rtl/sql_view_clause_scanner.sv =====
// sql_view_clause_scanner: top level, token and result registers around
// the lexer and the window cell row. depends on svcs_pkg, svcs_lexer, svcs_window.
//
// usage:
//   input channel: one transfer per byte of stored view text with in_tuser
//   low and the byte on in_tdata; a transfer with in_tuser high ends the
//   text (in_tdata ignored). exactly one result transfer follows each end.
//   result channel: out_tdata carries inspected and the four clause flags.
//   throughput: one input transfer per cycle while in_tready is high, set by
//   the lexer step and the one-shift window cell row.
//   result path: an end transfer passes through the token register, then
//   its result is loaded into the result register and shown from there.
//   stall: bytes keep flowing while a result waits; an end transfer is held
//   in the token register while the result register is full and out_tready
//   is low, and in_tready is low only while that end token waits.
//   reset: rst_n low for one clock returns lexer, window and flags to the
//   empty state; after an end transfer the block clears itself the same way.
`timescale 1ns / 1ps

module sql_view_clause_scanner import svcs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tuser,   // [0] action
  output logic       out_tvalid,
  input  logic       out_tready,
  // [0] inspected, [1] join flag, [2] group by flag, [3] where flag,
  // [4] aggregate flag, [7:5] zero
  output logic [7:0] out_tdata
);

  tok_t       tok_r, tok_nxt, tok_lex;
  logic       tok_v_r, tok_v_nxt;
  logic       in_acc;
  logic       consume;
  logic       out_v_r, out_v_nxt;
  logic [7:0] out_data_r, out_data_nxt;
  logic       res_v;
  logic       res_seen;
  flags_t     res_flags;

  assign in_tready = !(tok_v_r && tok_r.last && out_v_r && !out_tready);
  assign in_acc    = in_tvalid && in_tready;
  assign consume   = tok_v_r && !(tok_r.last && out_v_r && !out_tready);

  svcs_lexer u_lexer (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (in_acc),
    .action    (in_tuser),
    .data_byte (in_tdata),
    .tok_nxt   (tok_lex)
  );

  svcs_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .consume   (consume),
    .tok       (tok_r),
    .res_v     (res_v),
    .res_seen  (res_seen),
    .res_flags (res_flags)
  );

  always_comb begin
    tok_nxt      = in_acc ? tok_lex : tok_r;
    tok_v_nxt    = in_acc ? 1'b1 : (consume ? 1'b0 : tok_v_r);
    out_v_nxt    = res_v ? 1'b1 : (out_tready ? 1'b0 : out_v_r);
    out_data_nxt = res_v ? {3'b000, res_flags, res_seen} : out_data_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      tok_v_r <= tok_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tok_r      <= tok_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

  a_empty_no_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_data_r[0] |-> out_data_r[4:1] == '0)
    else $error("flags set on a result for empty text");

  a_block_only_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> tok_v_r && tok_r.last && out_v_r)
    else $error("input blocked without a waiting end token");

  a_result_from_end: assert property (@(posedge clk) disable iff (!rst_n)
    res_v |-> tok_v_r && tok_r.last && (!out_v_r || out_tready))
    else $error("result loaded over an untaken result");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> out_data_r[7:5] == '0)
    else $error("nonzero pad bits in result");

endmodule
